>>> rtl/mitx_pkg.sv
`default_nettype none

package mitx_pkg;

  localparam int unsigned INSTR_SPACE_BYTES = 16777216;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned RIDX_W   = 5;

  localparam logic [5:0] OP_REGIMM = 6'b000001;
  localparam logic [5:0] OP_BEQ    = 6'b000100;
  localparam logic [5:0] OP_ADDI   = 6'b001000;
  localparam logic [5:0] OP_ADDIU  = 6'b001001;
  localparam logic [5:0] OP_ANDI   = 6'b001100;
  localparam logic [5:0] OP_ORI    = 6'b001101;

  // opcodes that are decoded but not executed
  localparam logic [5:0] OP_BNE    = 6'b000101;
  localparam logic [5:0] OP_BLEZ   = 6'b000110;
  localparam logic [5:0] OP_BGTZ   = 6'b000111;
  localparam logic [5:0] OP_SLTI   = 6'b001010;
  localparam logic [5:0] OP_SLTIU  = 6'b001011;
  localparam logic [5:0] OP_XORI   = 6'b001110;
  localparam logic [5:0] OP_LUI    = 6'b001111;
  localparam logic [5:0] OP_LB     = 6'b100000;
  localparam logic [5:0] OP_LH     = 6'b100001;
  localparam logic [5:0] OP_LWL    = 6'b100010;
  localparam logic [5:0] OP_LW     = 6'b100011;
  localparam logic [5:0] OP_LBU    = 6'b100100;
  localparam logic [5:0] OP_LHU    = 6'b100101;
  localparam logic [5:0] OP_LWR    = 6'b100110;
  localparam logic [5:0] OP_SB     = 6'b101000;
  localparam logic [5:0] OP_SH     = 6'b101001;
  localparam logic [5:0] OP_SW     = 6'b101011;

  localparam logic [4:0] RT_BLTZ   = 5'b00000;
  localparam logic [4:0] RT_BGEZ   = 5'b00001;
  localparam logic [4:0] RT_BLTZAL = 5'b10000;
  localparam logic [4:0] RT_BGEZAL = 5'b10001;

  localparam logic [4:0] LINK_REG  = 5'b11111;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_TARGET   = 2'd2,
    ST_UNIMPL   = 2'd3
  } status_e;

  typedef struct packed {
    logic                   en;
    logic [RIDX_W-1:0]      idx;
    logic [XLEN-1:0]        data;
  } rf_wr_t;

endpackage

`default_nettype wire

>>> rtl/mips_itype_execute_unit_core.sv
// Stages: execute stage registers at accept, then output registers for the result.
// Throughput: one instruction per cycle unless the output stalls; register file read
//   at accept; execute, write back on advance; same-cycle writes bypass to operands.
// Reset: program counter cleared, register file valid bits cleared so every
//   register reads zero, pipeline and output emptied.
`default_nettype none

module mips_itype_execute_unit_core #(
  parameter int unsigned INSTR_SPACE_BYTES = mitx_pkg::INSTR_SPACE_BYTES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [31:0]                 instruction_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [1:0]                  status_o,
  output logic      [31:0]                 next_pc_o,
  output logic                             wrote_register_o,
  output logic      [4:0]                  write_index_o,
  output logic      [31:0]                 write_value_o
);

  localparam logic [33:0] TGT_LIMIT = 34'((INSTR_SPACE_BYTES + 3) / 4);

  // ---------------- execute stage registers
  logic        s1_valid_q;
  logic [31:0] instr_q;
  logic        byp_a_q, byp_b_q;
  logic [31:0] byp_val_q;
  logic [31:0] pc_q, pc_d;

  // ---------------- output registers
  logic                 out_valid_q;
  mitx_pkg::status_e    status_q, status_d;
  logic [31:0]          npc_q;
  logic                 wr_q;
  logic [4:0]           widx_q;
  logic [31:0]          wval_q;

  logic        s1_adv, s1_fire, in_fire;
  logic [31:0] rf_a, rf_b, opa, opb;
  mitx_pkg::rf_wr_t wb;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  mitx_regfile u_rf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wb),
    .rd_en_i     (in_fire),
    .rd_addr_a_i (instruction_i[25:21]),
    .rd_addr_b_i (instruction_i[20:16]),
    .rd_data_a_o (rf_a),
    .rd_data_b_o (rf_b)
  );

  assign opa = byp_a_q ? byp_val_q : rf_a;
  assign opb = byp_b_q ? byp_val_q : rf_b;

  // ---------------- execute
  logic [5:0]  op;
  logic [4:0]  rs, rt;
  logic [15:0] imm;
  logic [31:0] sext, zext, sum, link, tested;
  logic [33:0] target;
  logic        taken, is_branch, wr_raw;
  logic [4:0]  widx_raw;
  logic [31:0] wval_raw;
  logic        wr_fin;

  assign op   = instr_q[31:26];
  assign rs   = instr_q[25:21];
  assign rt   = instr_q[20:16];
  assign imm  = instr_q[15:0];
  assign sext = {{16{imm[15]}}, imm};
  assign zext = {16'h0000, imm};
  assign sum  = opa + sext;
  assign link = pc_q + 32'd2;
  assign tested = (rs == mitx_pkg::LINK_REG) ? link : opa;
  assign target = {2'b00, pc_q} + 34'd1 + {{18{imm[15]}}, imm};

  always_comb begin
    status_d  = mitx_pkg::ST_OK;
    is_branch = 1'b0;
    taken     = 1'b0;
    wr_raw    = 1'b0;
    widx_raw  = rt;
    wval_raw  = sum;
    case (op)
      mitx_pkg::OP_ADDI: begin
        if (((opa ^ sum) & (sext ^ sum) & 32'h8000_0000) != 32'd0) begin
          status_d = mitx_pkg::ST_OVERFLOW;
        end else begin
          wr_raw = 1'b1;
        end
      end
      mitx_pkg::OP_ADDIU: wr_raw = 1'b1;
      mitx_pkg::OP_ANDI: begin
        wr_raw   = 1'b1;
        wval_raw = opa & zext;
      end
      mitx_pkg::OP_ORI: begin
        wr_raw   = 1'b1;
        wval_raw = opa | zext;
      end
      mitx_pkg::OP_BEQ: begin
        is_branch = 1'b1;
        taken     = (opa == opb);
      end
      mitx_pkg::OP_REGIMM: begin
        case (rt)
          mitx_pkg::RT_BGEZ: begin
            is_branch = 1'b1;
            taken     = !opa[31];
          end
          mitx_pkg::RT_BGEZAL: begin
            is_branch = 1'b1;
            taken     = !tested[31];
            wr_raw    = 1'b1;
            widx_raw  = mitx_pkg::LINK_REG;
            wval_raw  = link;
          end
          mitx_pkg::RT_BLTZ, mitx_pkg::RT_BLTZAL: status_d = mitx_pkg::ST_UNIMPL;
          default: ;
        endcase
      end
      mitx_pkg::OP_BNE, mitx_pkg::OP_BLEZ, mitx_pkg::OP_BGTZ, mitx_pkg::OP_SLTI,
      mitx_pkg::OP_SLTIU, mitx_pkg::OP_XORI, mitx_pkg::OP_LUI, mitx_pkg::OP_LB,
      mitx_pkg::OP_LH, mitx_pkg::OP_LWL, mitx_pkg::OP_LW, mitx_pkg::OP_LBU,
      mitx_pkg::OP_LHU, mitx_pkg::OP_LWR, mitx_pkg::OP_SB, mitx_pkg::OP_SH,
      mitx_pkg::OP_SW: status_d = mitx_pkg::ST_UNIMPL;
      default: ;
    endcase

    pc_d = pc_q;
    if (is_branch) begin
      if (!taken) begin
        pc_d = link;
      end else if (target[33] || (target >= TGT_LIMIT)) begin
        status_d = mitx_pkg::ST_TARGET;
      end else begin
        pc_d = target[31:0];
      end
    end
    if (status_d != mitx_pkg::ST_OK) begin
      pc_d   = pc_q;
      wr_raw = 1'b0;
    end
  end

  assign wr_fin  = wr_raw && (widx_raw != 5'd0);
  assign wb.en   = s1_fire && wr_fin;
  assign wb.idx  = widx_raw;
  assign wb.data = wval_raw;

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      byp_a_q     <= 1'b0;
      byp_b_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        // a write landing at the same edge as the read is not in the read data
        byp_a_q    <= wb.en && (wb.idx == instruction_i[25:21]);
        byp_b_q    <= wb.en && (wb.idx == instruction_i[20:16]);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        pc_q        <= pc_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      instr_q   <= instruction_i;
      byp_val_q <= wb.data;
    end
    if (s1_fire) begin
      status_q <= status_d;
      npc_q    <= pc_d;
      wr_q     <= wr_fin;
      widx_q   <= wr_fin ? widx_raw : 5'd0;
      wval_q   <= wr_fin ? wval_raw : 32'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign next_pc_o        = npc_q;
  assign wrote_register_o = wr_q;
  assign write_index_o    = widx_q;
  assign write_value_o    = wval_q;

  // ---------------- assertions
  a_no_write_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !wrote_register_o) |-> (write_index_o == 5'd0 && write_value_o == 32'd0))
    else $error("result without a register write carries nonzero write fields");

  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb.en |-> (wb.idx != 5'd0))
    else $error("write back to register zero");

  a_error_no_side_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && status_d != mitx_pkg::ST_OK) |=> ($stable(pc_q) && out_valid_o && !wrote_register_o))
    else $error("faulting instruction changed state");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with free execute stage");

endmodule

`default_nettype wire

>>> rtl/mitx_regfile.sv
`default_nettype none

module mitx_regfile (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mitx_pkg::rf_wr_t             wr_i,
  input  wire logic                         rd_en_i,
  input  wire logic [mitx_pkg::RIDX_W-1:0]  rd_addr_a_i,
  input  wire logic [mitx_pkg::RIDX_W-1:0]  rd_addr_b_i,
  output logic      [mitx_pkg::XLEN-1:0]    rd_data_a_o,
  output logic      [mitx_pkg::XLEN-1:0]    rd_data_b_o
);

  logic [mitx_pkg::XLEN-1:0]     mem [mitx_pkg::NUM_REGS];
  logic [mitx_pkg::NUM_REGS-1:0] vld_q;
  logic [mitx_pkg::XLEN-1:0]     rdata_a_q;
  logic [mitx_pkg::XLEN-1:0]     rdata_b_q;
  logic                          vld_a_q;
  logic                          vld_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_a_q <= mem[rd_addr_a_i];
      rdata_b_q <= mem[rd_addr_b_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_a_q <= vld_q[rd_addr_a_i];
        vld_b_q <= vld_q[rd_addr_b_i];
      end
    end
  end

  assign rd_data_a_o = vld_a_q ? rdata_a_q : '0;
  assign rd_data_b_o = vld_b_q ? rdata_b_q : '0;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned RAMP_STEPS = 64;
  localparam int unsigned MAX_PRINTS = 40;
  localparam logic [4:0] RAMP_REG = 5'd7;

  // opcodes and a REGIMM rt that the block ignores
  localparam logic [5:0] OP_UNLISTED_LO = 6'b000000;
  localparam logic [5:0] OP_UNLISTED_HI = 6'b111111;
  localparam logic [4:0] RT_UNLISTED    = 5'b00010;

  localparam logic [5:0] UNIMPL_OPS [17] = '{
    mitx_pkg::OP_BNE, mitx_pkg::OP_BLEZ, mitx_pkg::OP_BGTZ, mitx_pkg::OP_SLTI,
    mitx_pkg::OP_SLTIU, mitx_pkg::OP_XORI, mitx_pkg::OP_LUI, mitx_pkg::OP_LB,
    mitx_pkg::OP_LH, mitx_pkg::OP_LWL, mitx_pkg::OP_LW, mitx_pkg::OP_LBU,
    mitx_pkg::OP_LHU, mitx_pkg::OP_LWR, mitx_pkg::OP_SB, mitx_pkg::OP_SH,
    mitx_pkg::OP_SW
  };

  typedef struct {
    mitx_pkg::status_e status;
    logic [31:0]       npc;
    logic              wrote;
    logic [4:0]        widx;
    logic [31:0]       wval;
  } retire_t;

  typedef struct {
    logic [31:0] word;
    bit          drain;  // hold off until every retirement is back
  } backlog_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] instruction_i = 32'h0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] next_pc_o;
  logic        wrote_register_o;
  logic [4:0]  write_index_o;
  logic [31:0] write_value_o;

  mips_itype_execute_unit_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .instruction_i    (instruction_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .next_pc_o        (next_pc_o),
    .wrote_register_o (wrote_register_o),
    .write_index_o    (write_index_o),
    .write_value_o    (write_value_o)
  );

  backlog_t    instr_backlog [$];
  retire_t     retire_q [$];
  logic [31:0] gpr_model [32];
  logic [31:0] pc_model;

  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned total_items = 0;
  int unsigned instr_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned trap_count = 0;
  int unsigned target_err_count = 0;
  int unsigned unimpl_count = 0;
  int unsigned write_count = 0;
  int unsigned taken_count = 0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic bit calm_phase();
    return (cycle_count % 640) < 160;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] encode_itype(input logic [5:0] op, input logic [4:0] rs,
                                               input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic bit is_unimplemented_op(input logic [5:0] op);
    foreach (UNIMPL_OPS[i])
      if (UNIMPL_OPS[i] == op) return 1'b1;
    return 1'b0;
  endfunction

  function automatic mitx_pkg::status_e resolve_branch(input bit taken, input logic [15:0] imm,
                                                       output logic [31:0] npc);
    longint target;
    npc = pc_model + 32'd2;
    if (!taken) return mitx_pkg::ST_OK;
    target = longint'(pc_model) + 1 + longint'($signed(imm));
    if (target < 0 || target * 4 >= longint'(mitx_pkg::INSTR_SPACE_BYTES))
      return mitx_pkg::ST_TARGET;
    npc = target[31:0];
    return mitx_pkg::ST_OK;
  endfunction

  function automatic void predict_retire(input logic [31:0] word);
    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [31:0] sext;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sum;
    logic [31:0] link;
    logic [31:0] tested;
    retire_t     r;
    op = word[31:26];
    rs = word[25:21];
    rt = word[20:16];
    imm = word[15:0];
    sext = {{16{imm[15]}}, imm};
    a = gpr_model[rs];
    b = gpr_model[rt];
    r.status = mitx_pkg::ST_OK;
    r.npc = pc_model;
    r.wrote = 1'b0;
    r.widx = rt;
    r.wval = 32'h0;
    case (op)
      mitx_pkg::OP_ADDI: begin
        sum = a + sext;
        if (a[31] == sext[31] && sum[31] != a[31]) begin
          r.status = mitx_pkg::ST_OVERFLOW;
        end else begin
          r.wrote = 1'b1;
          r.wval = sum;
        end
      end
      mitx_pkg::OP_ADDIU: begin
        r.wrote = 1'b1;
        r.wval = a + sext;
      end
      mitx_pkg::OP_ANDI: begin
        r.wrote = 1'b1;
        r.wval = a & {16'h0, imm};
      end
      mitx_pkg::OP_ORI: begin
        r.wrote = 1'b1;
        r.wval = a | {16'h0, imm};
      end
      mitx_pkg::OP_BEQ: r.status = resolve_branch(a == b, imm, r.npc);
      mitx_pkg::OP_REGIMM: begin
        if (rt == mitx_pkg::RT_BGEZ) begin
          r.status = resolve_branch(!a[31], imm, r.npc);
        end else if (rt == mitx_pkg::RT_BGEZAL) begin
          // link is written before the test, so rs == 31 sees the new value
          link = pc_model + 32'd2;
          tested = (rs == mitx_pkg::LINK_REG) ? link : a;
          r.status = resolve_branch(!tested[31], imm, r.npc);
          r.wrote = (r.status == mitx_pkg::ST_OK);
          r.widx = mitx_pkg::LINK_REG;
          r.wval = link;
        end else if (rt == mitx_pkg::RT_BLTZ || rt == mitx_pkg::RT_BLTZAL) begin
          r.status = mitx_pkg::ST_UNIMPL;
        end
      end
      default: if (is_unimplemented_op(op)) r.status = mitx_pkg::ST_UNIMPL;
    endcase
    if (r.status != mitx_pkg::ST_OK) begin
      r.npc = pc_model;
      r.wrote = 1'b0;
    end
    if (r.wrote && r.widx == 5'd0) r.wrote = 1'b0;
    if (!r.wrote) begin
      r.widx = 5'd0;
      r.wval = 32'h0;
    end
    if (r.wrote) gpr_model[r.widx] = r.wval;
    pc_model = r.npc;
    retire_q.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at %0t, result %0d: %s got %h expected %h", $realtime, instr_accepted,
               what, got, want);
  endtask

  task automatic queue_instr(input logic [31:0] word, input bit drain = 1'b0);
    backlog_t b;
    b.word = word;
    b.drain = drain;
    instr_backlog.push_back(b);
  endtask

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_offset();
    logic [15:0] off;
    if ($urandom_range(0, 3) == 0) return pick_imm();
    off = 16'($urandom_range(0, 128)) - 16'd64;
    return off;
  endfunction

  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [4:0] pick_regimm_rt();
    case ($urandom_range(0, 4))
      0: return mitx_pkg::RT_BGEZ;
      1: return mitx_pkg::RT_BGEZAL;
      2: return mitx_pkg::RT_BLTZ;
      3: return mitx_pkg::RT_BLTZAL;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // driver: presents the next instruction once the current one is taken
  always @(negedge clk_i) begin
    backlog_t item;
    logic     nxt_valid;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (instr_backlog.size() > 0 &&
                     !(instr_backlog[0].drain && retire_q.size() != 0)) begin
          item = instr_backlog.pop_front();
          instruction_i <= item.word;
          nxt_valid = 1'b1;
          send_gap = calm_phase() ? 0 : draw_gap();
        end
        in_valid_i <= nxt_valid;
      end
    end
  end

  // result side backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!calm_phase()) stall_left = draw_gap();
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    retire_t want;
    cycle_count++;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    if (out_taken) begin
      if (retire_q.size() == 0) begin
        report_mismatch("result with no instruction pending, next_pc", next_pc_o, 32'h0);
      end else begin
        want = retire_q.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (next_pc_o !== want.npc) report_mismatch("next_pc", next_pc_o, want.npc);
        if (wrote_register_o !== want.wrote)
          report_mismatch("wrote_register", 32'(wrote_register_o), 32'(want.wrote));
        if (write_index_o !== want.widx)
          report_mismatch("write_index", 32'(write_index_o), 32'(want.widx));
        if (write_value_o !== want.wval)
          report_mismatch("write_value", write_value_o, want.wval);
        case (want.status)
          mitx_pkg::ST_OVERFLOW: trap_count++;
          mitx_pkg::ST_TARGET:   target_err_count++;
          mitx_pkg::ST_UNIMPL:   unimpl_count++;
          default:               ;
        endcase
        if (want.wrote) write_count++;
      end
    end
    if (in_taken) begin
      predict_retire(instruction_i);
      instr_accepted++;
    end
    if (in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d of %0d instructions taken",
               IDLE_LIMIT, instr_accepted, total_items);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    int unsigned sel;

    foreach (gpr_model[i]) gpr_model[i] = 32'h0;
    pc_model = 32'h0;

    // negative target right at pc 0, then climb to the top of instruction space
    queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
    queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFFFE));
    for (int i = 0; i < 127; i++)
      queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd0, 5'd0, 16'h7FFF));
    queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd0, 5'd0, 16'd32766));  // last valid word
    queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd0, 5'd0, 16'h0000));   // one past the end
    queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
    queue_instr(encode_itype(mitx_pkg::OP_REGIMM, 5'd0, mitx_pkg::RT_BGEZAL, 16'h0000));
    for (int i = 0; i < 128; i++)
      queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));
    queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));
    queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFF80));   // back to pc 0

    // immediates at their extremes, writes to register zero
    queue_instr(encode_itype(mitx_pkg::OP_ADDIU, 5'd0, 5'd1, 16'h7FFF));
    queue_instr(encode_itype(mitx_pkg::OP_ADDIU, 5'd0, 5'd2, 16'h8000));
    queue_instr(encode_itype(mitx_pkg::OP_ORI, 5'd0, 5'd3, 16'hFFFF));
    queue_instr(encode_itype(mitx_pkg::OP_ANDI, 5'd2, 5'd4, 16'hFFFF));
    queue_instr(encode_itype(mitx_pkg::OP_ANDI, 5'd3, 5'd5, 16'h0000));
    queue_instr(encode_itype(mitx_pkg::OP_ORI, 5'd2, 5'd8, 16'hFFFF));
    queue_instr(encode_itype(mitx_pkg::OP_ADDI, 5'd2, 5'd6, 16'h8000));
    queue_instr(encode_itype(mitx_pkg::OP_ADDIU, 5'd1, 5'd0, 16'h1234));
    // branch flavors, link with rs == 31, unimplemented and ignored codes
    queue_instr(encode_itype(mitx_pkg::OP_BEQ, 5'd1, 5'd0, 16'h8000));
    queue_instr(encode_itype(mitx_pkg::OP_REGIMM, 5'd2, mitx_pkg::RT_BGEZ, 16'h7FFF));
    queue_instr(encode_itype(mitx_pkg::OP_REGIMM, 5'd1, mitx_pkg::RT_BGEZ, 16'h0003));
    queue_instr(encode_itype(mitx_pkg::OP_REGIMM, mitx_pkg::LINK_REG, mitx_pkg::RT_BGEZAL,
                             16'h0000));
    queue_instr(encode_itype(mitx_pkg::OP_REGIMM, 5'd2, mitx_pkg::RT_BGEZAL, 16'h0005));
    queue_instr(encode_itype(mitx_pkg::OP_REGIMM, 5'd0, mitx_pkg::RT_BGEZAL, 16'h8000));
    queue_instr(encode_itype(mitx_pkg::OP_REGIMM, 5'd2, mitx_pkg::RT_BLTZ, 16'h0001));
    queue_instr(encode_itype(mitx_pkg::OP_REGIMM, 5'd2, mitx_pkg::RT_BLTZAL, 16'h0001));
    queue_instr(encode_itype(mitx_pkg::OP_REGIMM, 5'd1, RT_UNLISTED, 16'h0001));
    queue_instr(encode_itype(mitx_pkg::OP_LUI, 5'd1, 5'd9, 16'hFFFF));
    queue_instr(encode_itype(mitx_pkg::OP_SW, 5'd1, 5'd9, 16'h0004));
    queue_instr(encode_itype(OP_UNLISTED_LO, 5'd1, 5'd9, 16'h0000));
    queue_instr(encode_itype(OP_UNLISTED_HI, 5'd31, 5'd31, 16'hFFFF));

    // chain of dependent adds on one register, then small steps around it
    queue_instr(encode_itype(mitx_pkg::OP_ADDI, RAMP_REG, RAMP_REG, 16'h7FFF), 1'b1);
    for (int i = 1; i < RAMP_STEPS; i++)
      queue_instr(encode_itype(mitx_pkg::OP_ADDI, RAMP_REG, RAMP_REG, 16'h7FFF));
    queue_instr(encode_itype(mitx_pkg::OP_ADDI, RAMP_REG, RAMP_REG, 16'h0001));
    queue_instr(encode_itype(mitx_pkg::OP_ADDIU, RAMP_REG, RAMP_REG, 16'h0001));
    queue_instr(encode_itype(mitx_pkg::OP_ADDI, RAMP_REG, RAMP_REG, 16'hFFFF));
    queue_instr(encode_itype(mitx_pkg::OP_ADDI, RAMP_REG, 5'd8, 16'h0000));
    queue_instr(encode_itype(mitx_pkg::OP_ADDIU, RAMP_REG, 5'd9, 16'hFFFF));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      rs = pick_reg();
      rt = pick_reg();
      if (sel < 60) begin
        case (sel % 4)
          0: op = mitx_pkg::OP_ADDI;
          1: op = mitx_pkg::OP_ADDIU;
          2: op = mitx_pkg::OP_ANDI;
          default: op = mitx_pkg::OP_ORI;
        endcase
        queue_instr(encode_itype(op, rs, rt, pick_imm()), (i % 400) == 0);
      end else if (sel < 72) begin
        if ($urandom_range(0, 1) == 0) rt = rs;
        queue_instr(encode_itype(mitx_pkg::OP_BEQ, rs, rt, pick_offset()), (i % 400) == 0);
      end else if (sel < 84) begin
        queue_instr(encode_itype(mitx_pkg::OP_REGIMM, rs, pick_regimm_rt(), pick_offset()),
                    (i % 400) == 0);
      end else if (sel < 92) begin
        op = UNIMPL_OPS[$urandom_range(0, 16)];
        queue_instr(encode_itype(op, rs, rt, pick_imm()), (i % 400) == 0);
      end else begin
        queue_instr($urandom(), (i % 400) == 0);
      end
    end
    total_items = instr_backlog.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (instr_accepted != total_items || retire_q.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("ran %0d instructions: %0d register writes, %0d overflow traps, %0d bad targets,",
             instr_accepted, write_count, trap_count, target_err_count);
    $display("%0d unimplemented; dependent add chain, branch climb to the last word",
             unimpl_count);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mitx_pkg.sv
rtl/mitx_regfile.sv
rtl/mips_itype_execute_unit_core.sv
dv/testbench.sv
